[rtl/wwp_pkg.sv]
`timescale 1ns / 1ps
// wwp_pkg: shared constants, controller state type and the command/status
// structs between wwp_ctrl and wwp_datapath. no dependencies.
package wwp_pkg;

    localparam int ROW_WIDTH_DEF = 20;
    localparam int CHAR_W        = 8;
    localparam int COL_W         = 5;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BREAK,
        ST_FLUSH
    } wwp_state_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic flush_row;
    } wwp_cmd_t;

    typedef struct packed {
        logic issue_ok;
        logic last_col;
        logic need_break;
        logic need_flush;
        logic flush_after;
    } wwp_status_t;

endpackage

[rtl/wwp_ctrl.sv]
`timescale 1ns / 1ps
// wwp_ctrl: sequencer for accepting text bytes and issuing row reads.
// depends on wwp_pkg.
module wwp_ctrl
    import wwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  wwp_status_t status,
    output wwp_cmd_t    cmd
);

    wwp_state_t state_reg;
    wwp_state_t state_next;
    logic       row_done;

    assign row_done = status.issue_ok && status.last_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.need_break)
                begin
                    state_next = ST_BREAK;
                end
                else if (status.need_flush)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BREAK:
            begin
                if (row_done)
                begin
                    state_next = status.flush_after ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (row_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd.accept    = 1'b0;
        cmd.issue     = 1'b0;
        cmd.flush_row = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_CHECK:
            begin
                in_stall = 1'b1;
            end
            ST_BREAK:
            begin
                cmd.issue = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.issue     = 1'b1;
                cmd.flush_row = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // a row is only ever started from the check step or right after a break row
    a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && $past(state_reg) != ST_FLUSH) |->
            ($past(state_reg) == ST_CHECK || $past(state_reg) == ST_BREAK))
        else $error("flush row entered from wrong state");

    a_break_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BREAK && $past(state_reg) != ST_BREAK) |->
            $past(state_reg) == ST_CHECK)
        else $error("break row entered from wrong state");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.accept) |-> in_stall)
        else $error("second item taken before check step");

endmodule

[rtl/wwp_datapath.sv]
`timescale 1ns / 1ps
// wwp_datapath: circular line buffer, break point tracking, read stage and
// output register. depends on wwp_pkg, driven by wwp_ctrl.
module wwp_datapath
    import wwp_pkg::*;
#(
    parameter int ROW_WIDTH = ROW_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  wwp_cmd_t          cmd,
    output wwp_status_t       status,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              last_char,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic [COL_W-1:0]  column,
    output logic              row_end,
    output logic              last_of_run,
    output logic              text_end
);

    localparam int AW    = $clog2(ROW_WIDTH + 1);
    localparam int DEPTH = 1 << AW;
    localparam int FW    = $clog2(ROW_WIDTH + 2);
    localparam int CW    = $clog2(ROW_WIDTH);

    localparam logic [FW-1:0] RW_F     = FW'(ROW_WIDTH);
    localparam logic [FW-1:0] RW1_F    = FW'(ROW_WIDTH + 1);
    localparam logic [CW-1:0] LAST_COL = CW'(ROW_WIDTH - 1);

    logic [CHAR_W-1:0] mem [DEPTH];

    logic [AW-1:0]     head_reg;
    logic [FW-1:0]     fill_reg;
    logic              ls_valid_reg;
    logic [FW-1:0]     ls_pos_reg;
    logic              last_reg;
    logic [FW-1:0]     chunk_reg;
    logic [FW-1:0]     skip_reg;
    logic [CW-1:0]     col_reg;

    logic              rd_valid_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_pad_reg;
    logic [CW-1:0]     rd_col_reg;
    logic              rd_row_end_reg;
    logic              rd_lor_reg;
    logic              rd_te_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [COL_W-1:0]  column_reg;
    logic              row_end_reg;
    logic              lor_reg;
    logic              te_reg;

    logic              is_space;
    logic              keep;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic              out_free;
    logic              issue_ok;
    logic              fire;
    logic              last_col;
    logic              flush_after;
    logic [FW-1:0]     chunk_sel;
    logic              pad;
    logic              lor;

    assign is_space    = (in_char == SPACE_CHAR);
    assign keep        = !((fill_reg == '0) && is_space);
    assign waddr       = head_reg + AW'(fill_reg);
    assign raddr       = head_reg + AW'(col_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign issue_ok    = !rd_valid_reg || out_free;
    assign fire        = cmd.issue && issue_ok;
    assign last_col    = (col_reg == LAST_COL);
    // a flush row follows the break row only at end of text with something left over
    assign flush_after = last_reg && (skip_reg != RW1_F);
    assign chunk_sel   = cmd.flush_row ? fill_reg : chunk_reg;
    assign pad         = (FW'(col_reg) >= chunk_sel);
    assign lor         = last_col && (cmd.flush_row || !flush_after);

    assign status.issue_ok    = issue_ok;
    assign status.last_col    = last_col;
    assign status.need_break  = (fill_reg == RW1_F);
    assign status.need_flush  = last_reg && (fill_reg != '0);
    assign status.flush_after = flush_after;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && keep)
        begin
            mem[waddr] <= in_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            fill_reg     <= '0;
            ls_valid_reg <= 1'b0;
            last_reg     <= 1'b0;
            col_reg      <= '0;
        end
        else if (cmd.accept)
        begin
            last_reg <= last_char;
            if (keep)
            begin
                fill_reg <= fill_reg + FW'(1);
                // remember the last space in positions 1 to ROW_WIDTH-1
                if (is_space && fill_reg != '0 && fill_reg < RW_F)
                begin
                    ls_valid_reg <= 1'b1;
                end
            end
        end
        else if (fire)
        begin
            col_reg <= last_col ? '0 : col_reg + CW'(1);
            if (last_col)
            begin
                ls_valid_reg <= 1'b0;
                if (cmd.flush_row)
                begin
                    fill_reg <= '0;
                end
                else
                begin
                    head_reg <= head_reg + AW'(skip_reg);
                    fill_reg <= RW1_F - skip_reg;
                end
            end
        end
    end

    // break point, latched when the row overflows by one character
    always_ff @(posedge clk)
    begin
        if (cmd.accept && keep && is_space && fill_reg != '0 && fill_reg < RW_F)
        begin
            ls_pos_reg <= fill_reg;
        end
        if (cmd.accept && fill_reg == RW_F)
        begin
            if (is_space)
            begin
                chunk_reg <= RW_F;
                skip_reg  <= RW1_F;
            end
            else if (ls_valid_reg)
            begin
                chunk_reg <= ls_pos_reg;
                skip_reg  <= ls_pos_reg + FW'(1);
            end
            else
            begin
                chunk_reg <= RW_F;
                skip_reg  <= RW_F;
            end
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rd_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_data_reg    <= mem[raddr];
            rd_pad_reg     <= pad;
            rd_col_reg     <= col_reg;
            rd_row_end_reg <= last_col;
            rd_lor_reg     <= lor;
            rd_te_reg      <= lor && last_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && rd_valid_reg)
        begin
            out_char_reg <= rd_pad_reg ? SPACE_CHAR : rd_data_reg;
            column_reg   <= COL_W'(rd_col_reg);
            row_end_reg  <= rd_row_end_reg;
            lor_reg      <= rd_lor_reg;
            te_reg       <= rd_te_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign column      = column_reg;
    assign row_end     = row_end_reg;
    assign last_of_run = lor_reg;
    assign text_end    = te_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= RW1_F)
        else $error("line buffer overfilled");

    a_space_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ls_valid_reg |-> (ls_pos_reg != '0 && ls_pos_reg < fill_reg))
        else $error("tracked space outside buffered text");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_col && cmd.flush_row) |=> (fill_reg == '0 && !ls_valid_reg))
        else $error("buffer not empty after flush row");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.issue)
        else $error("byte taken while a row is issued");

endmodule

[rtl/word_wrap_padded_rows.sv]
`timescale 1ns / 1ps
// word_wrap_padded_rows: greedy word wrap of a byte stream into space-padded
// rows. top level, instantiates wwp_ctrl and wwp_datapath, uses wwp_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | in_char, last_char
//   out     | out_valid/out_stall| out_char, column, row_end, last_of_run,
//           |                    | text_end
//
// a byte is accepted, then the buffer state is checked before the next byte
// is taken. a finished row is read out one buffer read per column through
// the single read port; a flush at the end of text reads out another row.
// out_stall holds the read stage and output register; reads resume as soon
// as the output register drains. reset clears control state only, the line
// buffer needs no clearing pass.
module word_wrap_padded_rows
    import wwp_pkg::*;
#(
    parameter int ROW_WIDTH = ROW_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              last_char,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic [COL_W-1:0]  column,
    output logic              row_end,
    output logic              last_of_run,
    output logic              text_end
);

    wwp_cmd_t    cmd;
    wwp_status_t status;

    wwp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wwp_datapath #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_char     (in_char),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .column      (column),
        .row_end     (row_end),
        .last_of_run (last_of_run),
        .text_end    (text_end)
    );

endmodule

[test/word_wrap_padded_rows_tb.sv]
`timescale 1ns / 1ps
// word_wrap_padded_rows_tb: self-checking bench for word_wrap_padded_rows.
// a built-in word wrap predictor checks items with no typed expectation;
// stimulus is a directed table then random texts. depends on wwp_pkg and the rtl.
module word_wrap_padded_rows_tb;
    import wwp_pkg::*;

    localparam int ROW_W      = ROW_WIDTH_DEF;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AT    = 60;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_LEN   = 3 * ROW_W;
    localparam int RAND_ITEMS = 125;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic              row_end;
        logic              run_last;
        logic              text_end;
    } glyph_t;

    // typed_n < 0: expectation comes from the predictor
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              fin;
        int                typed_n;
        logic [CHAR_W-1:0] typed_head;
    } text_item_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CHAR_W-1:0] in_char;
    logic              last_char;
    logic              out_valid;
    logic              out_stall;
    logic [CHAR_W-1:0] out_char;
    logic [COL_W-1:0]  column;
    logic              row_end;
    logic              last_of_run;
    logic              text_end;

    // predictor state
    logic [CHAR_W-1:0] pred_store [0:ROW_W];
    int                fill_cnt;
    glyph_t            step_glyphs[$];

    text_item_t        text_q[$];
    glyph_t            glyph_q[$];
    int                err_cnt;
    int                items_in;
    int                items_out;
    int                dir_n;
    int                idle_cycles;

    word_wrap_padded_rows #(
        .ROW_WIDTH(ROW_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .column     (column),
        .row_end    (row_end),
        .last_of_run(last_of_run),
        .text_end   (text_end)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic note_diff(input string what, input logic [7:0] want, input logic [7:0] got);
        err_cnt++;
        $display("mismatch %s at result %0d: expected %0h, got %0h", what, items_out, want, got);
    endtask

    function automatic void row_push(input int keep);
        glyph_t g;
        for (int c = 0; c < ROW_W; c++)
        begin
            g.ch       = (c < keep) ? pred_store[c] : SPACE_CHAR;
            g.col      = COL_W'(c);
            g.row_end  = (c == ROW_W - 1);
            g.run_last = 1'b0;
            g.text_end = 1'b0;
            step_glyphs.push_back(g);
        end
    endfunction

    // one byte through the greedy wrap; results land in step_glyphs
    function automatic void wrap_byte(input logic [CHAR_W-1:0] ch, input logic fin);
        int     brk;
        int     s;
        glyph_t g;
        step_glyphs.delete();
        if (fill_cnt > ROW_W)
            fill_cnt = ROW_W;
        if (!(fill_cnt == 0 && ch == SPACE_CHAR))
        begin
            pred_store[fill_cnt] = ch;
            fill_cnt++;
        end
        if (fill_cnt == ROW_W + 1)
        begin
            brk = ROW_W;
            if (pred_store[ROW_W] != SPACE_CHAR)
            begin
                for (int i = ROW_W - 1; i > 0; i--)
                begin
                    if (pred_store[i] == SPACE_CHAR)
                    begin
                        brk = i;
                        break;
                    end
                end
            end
            row_push(brk);
            // drop the row and the spaces that would lead the next one
            s = brk;
            while (s < fill_cnt && pred_store[s] == SPACE_CHAR)
                s++;
            for (int i = 0; i < fill_cnt - s; i++)
                pred_store[i] = pred_store[i + s];
            fill_cnt -= s;
        end
        if (fin)
        begin
            if (fill_cnt > 0)
                row_push(fill_cnt);
            fill_cnt = 0;
        end
        if (step_glyphs.size() > 0)
        begin
            g = step_glyphs.pop_back();
            g.run_last = 1'b1;
            g.text_end = fin;
            step_glyphs.push_back(g);
        end
    endfunction

    task automatic add_item(input logic [7:0] ch, input logic fin, input int typed_n,
                            input logic [7:0] head);
        text_item_t t;
        t.ch         = ch;
        t.fin        = fin;
        t.typed_n    = typed_n;
        t.typed_head = head;
        text_q.push_back(t);
    endtask

    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(1, 31));
        return 8'($urandom_range(33, 255));
    endfunction

    // mostly words and gaps; some noise texts and some texts of spaces only
    task automatic add_random_text();
        int kind;
        int n_words;
        int len;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                add_item(SPACE_CHAR, i == len - 1, -1, 8'h00);
        end
        else if (kind == 1)
        begin
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                add_item(($urandom_range(0, 3) == 0) ? SPACE_CHAR : 8'($urandom_range(1, 255)),
                         i == len - 1, -1, 8'h00);
        end
        else
        begin
            n_words = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) add_item(SPACE_CHAR, 1'b0, -1, 8'h00);
            for (int w = 0; w < n_words; w++)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 26) : $urandom_range(1, 9);
                repeat (len) add_item(word_char(), 1'b0, -1, 8'h00);
                if (w < n_words - 1 || $urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2)) add_item(SPACE_CHAR, 1'b0, -1, 8'h00);
            end
            add_item(word_char(), 1'b1, -1, 8'h00);
        end
    endtask

    initial
    begin : run
        for (int i = 0; i <= ROW_W; i++)
            pred_store[i] = 8'h00;
        fill_cnt  = 0;
        err_cnt   = 0;
        items_in  = 0;
        items_out = 0;
        rst_n <= 1'b0;

        // single-character texts near the ends of the byte range (FF and 01)
        add_item(8'hFF, 1'b1, ROW_W, 8'hFF);
        add_item(8'h01, 1'b1, ROW_W, 8'h01);
        // a leading space is dropped
        add_item(SPACE_CHAR, 1'b0, 0, 8'h00);
        add_item("x", 1'b1, ROW_W, "x");
        // a full row followed by a space, then the text ends on an empty buffer
        for (int i = 0; i < ROW_W; i++)
            add_item(8'("a" + i), 1'b0, -1, 8'h00);
        add_item(SPACE_CHAR, 1'b0, -1, 8'h00);
        add_item(SPACE_CHAR, 1'b1, 0, 8'h00);
        dir_n = text_q.size();
        while (text_q.size() < dir_n + RAND_ITEMS)
            add_random_text();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (text_q.size() != 0 || in_valid || glyph_q.size() != 0);
        repeat (TAIL_LEN) @(posedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : sender
        text_item_t cur;
        glyph_t     g;
        int         burst_left;
        int         gap_left;
        int         popped;
        in_valid  <= 1'b0;
        in_char   <= SPACE_CHAR;
        last_char <= 1'b0;
        burst_left = 0;
        gap_left   = 0;
        popped     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                wrap_byte(cur.ch, cur.fin);
                if (cur.typed_n < 0)
                begin
                    foreach (step_glyphs[i])
                        glyph_q.push_back(step_glyphs[i]);
                end
                else
                begin
                    for (int c = 0; c < cur.typed_n; c++)
                    begin
                        g.ch       = (c == 0) ? cur.typed_head : SPACE_CHAR;
                        g.col      = COL_W'(c);
                        g.row_end  = (c == ROW_W - 1);
                        g.run_last = (c == ROW_W - 1);
                        g.text_end = cur.fin && (c == ROW_W - 1);
                        glyph_q.push_back(g);
                    end
                end
                items_in++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (text_q.size() == 0
                         || ((popped == dir_n || popped == dir_n + 70) && glyph_q.size() != 0))
                    in_valid <= 1'b0;
                else
                begin
                    cur = text_q.pop_front();
                    popped++;
                    in_char   <= cur.ch;
                    last_char <= cur.fin;
                    in_valid  <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        int mode_left;
        int stall_pct;
        bit held;
        mode_left = 0;
        stall_pct = 0;
        held      = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            // one long hold so the block backs up onto its input
            if (!held && items_in >= HOLD_AT)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(10, 80);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            mode_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : scoreboard
        glyph_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (glyph_q.size() == 0)
                note_diff("unexpected result", 8'h00, out_char);
            else
            begin
                want = glyph_q.pop_front();
                if (out_char !== want.ch)
                    note_diff("out_char", want.ch, out_char);
                if (column !== want.col)
                    note_diff("column", 8'(want.col), 8'(column));
                if (row_end !== want.row_end)
                    note_diff("row_end", 8'(want.row_end), 8'(row_end));
                if (last_of_run !== want.run_last)
                    note_diff("last_of_run", 8'(want.run_last), 8'(last_of_run));
                if (text_end !== want.text_end)
                    note_diff("text_end", 8'(want.text_end), 8'(text_end));
            end
            items_out++;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
